/* hw/rtl/gnbt_pkg.sv */
// Shared constants and types for the gated nearest-box tracker.
`default_nettype none

package gnbt_pkg;

  localparam int COORD_BITS_DEF = 12;

  // Q8 low-pass rate
  localparam int RATE_BITS  = 9;
  localparam int RATE_SHIFT = 8;
  localparam logic [RATE_BITS-1:0] RATE_ONE   = 9'd256;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 9'd192;

  // sideband widths
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 1;

  typedef enum logic {
    FUNC_CAND   = 1'b0,
    FUNC_REINIT = 1'b1
  } func_t;

endpackage

`default_nettype wire

/* hw/rtl/gated_nearest_box_tracker.sv */
// Top level of the gated nearest-box tracker.
`default_nettype none

// Gated nearest-box tracker. Candidate boxes stream in one per transfer, with
// tlast on the last box of a frame; tuser carries the reinit selector and the
// box-valid flag. One item is taken per clock: each transfer goes into an
// input register, and the gate test, the squared-distance compare against the
// running minimum and, on the last item of a frame, the size filter and the
// window rebuild all resolve combinationally between that register and the
// track state and the result register. Only a frame-closing item waits, and
// only while the result register is still full and not being taken. filter_rate
// is written through cfg_wr_en / cfg_wr_data and should be changed only while
// the block is idle.
module gated_nearest_box_tracker #(
  parameter int COORD_BITS = gnbt_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // configuration: filter_rate
  input  logic                                  cfg_wr_en,
  input  logic [gnbt_pkg::RATE_BITS-1:0]        cfg_wr_data,
  // input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // box_x, box_y, box_w, box_h
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  // func, box_valid
  input  logic [gnbt_pkg::IN_USER_W-1:0]        s_tuser,
  input  logic                                  s_tlast,
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // track_x, track_y, track_w, track_h, track_cx, track_cy,
  // prior_cx, prior_cy
  output logic [((8*COORD_BITS+12+7)/8)*8-1:0]  m_tdata,
  // found
  output logic [gnbt_pkg::OUT_USER_W-1:0]       m_tuser
);
  import gnbt_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int TRK_W  = C + 2;
  localparam int WIN_W  = C + 4;
  localparam int WSZ_W  = C + 3;
  localparam int CMP_W  = C + 5;
  localparam int DX_W   = C + 3;
  localparam int SQ_W   = 2 * DX_W;
  localparam int DIST_W = 2 * TRK_W + 1;
  localparam int OUT_DW = ((8*C+12+7)/8)*8;

  // configuration
  logic [RATE_BITS-1:0] rate;
  logic [RATE_BITS-1:0] rate_sat;

  // input register
  logic         in_v;
  func_t        in_func;
  logic         in_bvalid;
  logic         in_last;
  logic [C-1:0] in_x, in_y, in_w, in_h;

  // track state
  logic signed [TRK_W-1:0] trk_x, trk_y;
  logic [C-1:0]            trk_w, trk_h;
  logic signed [WIN_W-1:0] win_x, win_y;
  logic [WSZ_W-1:0]        win_w, win_h;
  logic signed [TRK_W-1:0] cen_x, cen_y, old_cen_x, old_cen_y;
  logic [DIST_W-1:0]       best_dist;
  logic [C-1:0]            best_x, best_y, best_w, best_h;
  logic                    have_best;

  // result register
  logic              out_v;
  logic [OUT_DW-1:0] out_data;
  logic              out_found;

  logic advance, closes, do_reinit, do_close, do_track;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (cfg_wr_en) begin
      rate <= cfg_wr_data;
    end
  end

  assign rate_sat = (rate > RATE_ONE) ? RATE_ONE : rate;

  // ---------------------------------------------------------------- input
  assign closes   = (in_func == FUNC_CAND) && in_last;
  assign advance  = in_v && (!closes || !out_v || m_tready);
  assign s_tready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func   <= func_t'(s_tuser[0]);
      in_bvalid <= s_tuser[1];
      in_last   <= s_tlast;
      in_x      <= s_tdata[0*C +: C];
      in_y      <= s_tdata[1*C +: C];
      in_w      <= s_tdata[2*C +: C];
      in_h      <= s_tdata[3*C +: C];
    end
  end

  // ---------------------------------------------------------- gate and score
  logic [C:0]               cx, cy;
  logic signed [CMP_W-1:0]  cx_s, cy_s, wx_lo, wx_hi, wy_lo, wy_hi;
  logic                     gated;
  logic signed [DX_W-1:0]   dx, dy;
  logic signed [SQ_W-1:0]   dx_sq, dy_sq;
  logic [DIST_W-1:0]        cand_dist;
  logic                     take;

  assign cx = (C+1)'(in_x) + (C+1)'(in_w >> 1);
  assign cy = (C+1)'(in_y) + (C+1)'(in_h >> 1);

  assign cx_s  = CMP_W'(cx);
  assign cy_s  = CMP_W'(cy);
  assign wx_lo = CMP_W'(win_x);
  assign wy_lo = CMP_W'(win_y);
  assign wx_hi = wx_lo + CMP_W'(win_w);
  assign wy_hi = wy_lo + CMP_W'(win_h);

  // strictly inside: an empty window admits nothing
  assign gated = (cx_s > wx_lo) && (cx_s < wx_hi) && (cy_s > wy_lo) && (cy_s < wy_hi);

  assign dx        = DX_W'(cx) - DX_W'(cen_x);
  assign dy        = DX_W'(cy) - DX_W'(cen_y);
  assign dx_sq     = SQ_W'(dx) * SQ_W'(dx);
  assign dy_sq     = SQ_W'(dy) * SQ_W'(dy);
  assign cand_dist = DIST_W'(dx_sq) + DIST_W'(dy_sq);

  // strict less-than keeps the earliest box on a tie
  assign take = in_v && (in_func == FUNC_CAND) && in_bvalid && gated &&
                (!have_best || (cand_dist < best_dist));

  // ------------------------------------------------------------- frame close
  // Filter both the stored winner and the current box, then pick, so the
  // distance product never feeds the filter products.
  logic [C-1:0] nw_best, nh_best, nw_cand, nh_cand;

  gnbt_size_filter #(.COORD_BITS(C)) u_filt_wb (
    .old_size (trk_w), .new_size (best_w), .rate (rate_sat), .size (nw_best)
  );
  gnbt_size_filter #(.COORD_BITS(C)) u_filt_hb (
    .old_size (trk_h), .new_size (best_h), .rate (rate_sat), .size (nh_best)
  );
  gnbt_size_filter #(.COORD_BITS(C)) u_filt_wc (
    .old_size (trk_w), .new_size (in_w), .rate (rate_sat), .size (nw_cand)
  );
  gnbt_size_filter #(.COORD_BITS(C)) u_filt_hc (
    .old_size (trk_h), .new_size (in_h), .rate (rate_sat), .size (nh_cand)
  );

  logic               have;
  logic [C-1:0]       fx, fy, fw, fh, nw, nh;
  logic [C:0]         ncx, ncy;

  assign have = have_best || take;
  assign fx   = take ? in_x : best_x;
  assign fy   = take ? in_y : best_y;
  assign fw   = take ? in_w : best_w;
  assign fh   = take ? in_h : best_h;
  assign nw   = take ? nw_cand : nw_best;
  assign nh   = take ? nh_cand : nh_best;
  assign ncx  = (C+1)'(fx) + (C+1)'(fw >> 1);
  assign ncy  = (C+1)'(fy) + (C+1)'(fh >> 1);

  // new track: reinit loads the box, a close recentres on the winner
  logic signed [TRK_W-1:0] ld_x, ld_y, ld_cx, ld_cy;
  logic [C-1:0]            ld_w, ld_h;

  always_comb begin
    if (in_func == FUNC_REINIT) begin
      ld_x  = TRK_W'(in_x);
      ld_y  = TRK_W'(in_y);
      ld_w  = in_w;
      ld_h  = in_h;
      ld_cx = TRK_W'(cx);
      ld_cy = TRK_W'(cy);
    end else begin
      ld_x  = TRK_W'(ncx) - TRK_W'(nw >> 1);
      ld_y  = TRK_W'(ncy) - TRK_W'(nh >> 1);
      ld_w  = nw;
      ld_h  = nh;
      // edge plus half size lands back on the winner centre exactly
      ld_cx = TRK_W'(ncx);
      ld_cy = TRK_W'(ncy);
    end
  end

  assign do_reinit = advance && (in_func == FUNC_REINIT);
  assign do_close  = advance && closes;
  assign do_track  = do_reinit || (do_close && have);

  always_ff @(posedge clk) begin
    if (rst) begin
      trk_x     <= '0;
      trk_y     <= '0;
      trk_w     <= '0;
      trk_h     <= '0;
      win_x     <= '0;
      win_y     <= '0;
      win_w     <= '0;
      win_h     <= '0;
      cen_x     <= '0;
      cen_y     <= '0;
      old_cen_x <= '0;
      old_cen_y <= '0;
      have_best <= 1'b0;
    end else begin
      if (do_track) begin
        trk_x     <= ld_x;
        trk_y     <= ld_y;
        trk_w     <= ld_w;
        trk_h     <= ld_h;
        win_x     <= WIN_W'(ld_x) - (WIN_W'(ld_w) << 1);
        win_y     <= WIN_W'(ld_y) - (WIN_W'(ld_h) << 1);
        win_w     <= WSZ_W'(ld_w) + (WSZ_W'(ld_w) << 2);
        win_h     <= WSZ_W'(ld_h) + (WSZ_W'(ld_h) << 2);
        cen_x     <= ld_cx;
        cen_y     <= ld_cy;
        old_cen_x <= do_reinit ? ld_cx : cen_x;
        old_cen_y <= do_reinit ? ld_cy : cen_y;
      end
      if (do_reinit || do_close) begin
        have_best <= 1'b0;
      end else if (advance && take) begin
        have_best <= 1'b1;
      end
    end
  end

  // winner payload: only read while have_best is set
  always_ff @(posedge clk) begin
    if (advance && take) begin
      best_dist <= cand_dist;
      best_x    <= in_x;
      best_y    <= in_y;
      best_w    <= in_w;
      best_h    <= in_h;
    end
  end

  // ------------------------------------------------------------------ result
  logic signed [TRK_W-1:0] r_x, r_y, r_cx, r_cy, r_px, r_py;
  logic [C-1:0]            r_w, r_h;

  assign r_x  = have ? ld_x  : trk_x;
  assign r_y  = have ? ld_y  : trk_y;
  assign r_w  = have ? ld_w  : trk_w;
  assign r_h  = have ? ld_h  : trk_h;
  assign r_cx = have ? ld_cx : cen_x;
  assign r_cy = have ? ld_cy : cen_y;
  assign r_px = have ? cen_x : old_cen_x;
  assign r_py = have ? cen_y : old_cen_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (do_close) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_close) begin
      out_found <= have;
      out_data  <= OUT_DW'({r_py, r_px, r_cy, r_cx, r_h, r_w, r_y, r_x});
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_data;
  assign m_tuser  = OUT_USER_W'(out_found);

endmodule

`default_nettype wire

/* hw/rtl/gnbt_size_filter.sv */
// Q8 low-pass blend of an old and a new box size.
`default_nettype none

module gnbt_size_filter #(
  parameter int COORD_BITS = gnbt_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]          old_size,
  input  logic [COORD_BITS-1:0]          new_size,
  input  logic [gnbt_pkg::RATE_BITS-1:0] rate,
  output logic [COORD_BITS-1:0]          size
);
  import gnbt_pkg::*;

  localparam int PROD_W = COORD_BITS + RATE_BITS;

  logic [RATE_BITS-1:0] keep;
  logic [PROD_W-1:0]    prod_old;
  logic [PROD_W-1:0]    prod_new;
  logic [PROD_W:0]      sum;

  // rate is already saturated to one, so keep never wraps
  assign keep     = RATE_ONE - rate;
  assign prod_old = PROD_W'(old_size) * PROD_W'(rate);
  assign prod_new = PROD_W'(new_size) * PROD_W'(keep);
  assign sum      = (PROD_W+1)'(prod_old) + (PROD_W+1)'(prod_new);
  // the weights add up to one, so the blend always fits the coordinate width
  assign size     = sum[RATE_SHIFT +: COORD_BITS];

endmodule

`default_nettype wire

/* hw/rtl/gnbt_checker.sv */
// Port-level checks for the gated nearest-box tracker, bound to the top level.
`default_nettype none

module gnbt_checker #(
  parameter int COORD_BITS = gnbt_pkg::COORD_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [gnbt_pkg::IN_USER_W-1:0]        s_tuser,
  input logic                                  s_tlast,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((8*COORD_BITS+12+7)/8)*8-1:0]  m_tdata,
  input logic [gnbt_pkg::OUT_USER_W-1:0]       m_tuser
);
  import gnbt_pkg::*;

  logic close_xfer;

  assign close_xfer = s_tvalid && s_tready && s_tlast && (s_tuser[0] == FUNC_CAND);

  // nothing is pending on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // input only stalls behind a full, blocked result register
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while result side is free");

  // a frame-closing transfer yields a result once the output can move
  a_close_gives_result: assert property (@(posedge clk) disable iff (rst)
    close_xfer ##1 m_tready |=> m_tvalid)
    else $error("frame close produced no result");

  // a blocked result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("blocked result changed");

endmodule

bind gated_nearest_box_tracker gnbt_checker #(.COORD_BITS(COORD_BITS)) u_gnbt_checker (.*);

`default_nettype wire
